@@ rtl/dmp_pkg.sv @@
// Shared types and constants for the door motion profile block.
// Used by the configuration registers, the state machine and the top level.
`timescale 1ns / 1ps

package dmp_pkg;

  // Widths of the item and result fields
  localparam int unsigned SpeedMagW = 12;
  localparam int unsigned SpeedW    = 13;
  localparam int unsigned StateW    = 4;
  localparam int unsigned SwitchN   = 4;
  localparam int unsigned CfgIdxW   = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCreep = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSlow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFast  = 2'd2;

  // Reset values of the speed magnitudes
  localparam logic [SpeedMagW-1:0] CreepRst = 12'd100;
  localparam logic [SpeedMagW-1:0] SlowRst  = 12'd200;
  localparam logic [SpeedMagW-1:0] FastRst  = 12'd400;

  // Switch bit positions, open end first
  localparam int unsigned SwOpenEnd   = 0;
  localparam int unsigned SwOpenZone  = 1;
  localparam int unsigned SwCloseZone = 2;
  localparam int unsigned SwCloseEnd  = 3;

  // One control tick
  typedef struct packed {
    logic               direction;  // 1 toward closed, 0 toward open
    logic [SwitchN-1:0] switches;   // bit0 open end .. bit3 close end
  } dmp_item_t;

  // Speed magnitudes from the configuration registers
  typedef struct packed {
    logic [SpeedMagW-1:0] creep;
    logic [SpeedMagW-1:0] slow;
    logic [SpeedMagW-1:0] fast;
  } dmp_cfg_t;

endpackage

@@ rtl/dmp_cfg_regs.sv @@
// Speed magnitude configuration registers of the door motion profile block.
// Depends on dmp_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module dmp_cfg_regs import dmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CfgIdxW-1:0]   wr_index_i,
  input  logic [SpeedMagW-1:0] wr_data_i,
  output dmp_cfg_t             cfg_o
);

  dmp_cfg_t cfg_q;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.creep <= CreepRst;
      cfg_q.slow  <= SlowRst;
      cfg_q.fast  <= FastRst;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        RegCreep: cfg_q.creep <= wr_data_i;
        RegSlow:  cfg_q.slow  <= wr_data_i;
        RegFast:  cfg_q.fast  <= wr_data_i;
        default:  ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/dmp_fsm.sv @@
// Door motion state machine: switch edge detection, zone sequencing and speed.
// Depends on dmp_pkg for the item and configuration types.
`timescale 1ns / 1ps

module dmp_fsm import dmp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  dmp_item_t                item_i,
  input  dmp_cfg_t                 cfg_i,
  output logic signed [SpeedW-1:0] speed_o,
  output logic [StateW-1:0]        state_o
);

  typedef enum logic [StateW-1:0] {
    ST_INIT    = 4'd0,
    ST_HOMING  = 4'd1,
    ST_CLOSED  = 4'd2,
    ST_OACC    = 4'd3,
    ST_OFAST   = 4'd4,
    ST_ODEC    = 4'd5,
    ST_OPENED  = 4'd6,
    ST_CACC    = 4'd7,
    ST_CFAST   = 4'd8,
    ST_CDEC    = 4'd9
  } state_e;

  state_e                     state_q, state_d;
  logic signed [SpeedW-1:0]   speed_q, speed_d;
  logic [SwitchN-1:0]         prev_sw_q;
  logic [SwitchN-1:0]         ev;
  logic signed [SpeedW-1:0]   creep_p, creep_n, slow_p, slow_n, fast_p, fast_n;
  logic                       dir;

  // Switch events are changes since the previous tick
  assign ev  = item_i.switches ^ prev_sw_q;
  assign dir = item_i.direction;

  // Signed speeds from the magnitudes
  assign creep_p = $signed({1'b0, cfg_i.creep});
  assign slow_p  = $signed({1'b0, cfg_i.slow});
  assign fast_p  = $signed({1'b0, cfg_i.fast});
  assign creep_n = -creep_p;
  assign slow_n  = -slow_p;
  assign fast_n  = -fast_p;

  // Next state and speed; a zone event wins over a reversal
  always_comb begin
    state_d = state_q;
    speed_d = speed_q;
    unique case (state_q)
      ST_INIT: state_d = ST_HOMING;
      ST_HOMING: begin
        if (dir) begin
          speed_d = creep_p;
          if (ev[SwCloseEnd]) state_d = ST_CLOSED;
        end else begin
          speed_d = creep_n;
          if (ev[SwOpenEnd]) state_d = ST_OPENED;
        end
      end
      ST_CLOSED: begin
        speed_d = '0;
        if (!dir) state_d = ST_OACC;
      end
      ST_OACC: begin
        speed_d = slow_n;
        if (ev[SwCloseZone]) state_d = ST_OFAST;
        else if (dir)        state_d = ST_CDEC;
      end
      ST_OFAST: begin
        speed_d = fast_n;
        if (ev[SwOpenZone]) state_d = ST_ODEC;
        else if (dir)       state_d = ST_CFAST;
      end
      ST_ODEC: begin
        speed_d = slow_n;
        if (ev[SwOpenEnd]) state_d = ST_OPENED;
        else if (dir)      state_d = ST_CACC;
      end
      ST_OPENED: begin
        speed_d = '0;
        if (dir) state_d = ST_CACC;
      end
      ST_CACC: begin
        speed_d = slow_p;
        if (ev[SwOpenZone]) state_d = ST_CFAST;
        else if (!dir)      state_d = ST_ODEC;
      end
      ST_CFAST: begin
        speed_d = fast_p;
        if (ev[SwCloseZone]) state_d = ST_CDEC;
        else if (!dir)       state_d = ST_OFAST;
      end
      ST_CDEC: begin
        speed_d = slow_p;
        if (ev[SwCloseEnd]) state_d = ST_CLOSED;
        else if (!dir)      state_d = ST_OACC;
      end
      default: state_d = ST_HOMING;
    endcase
  end

  // Hold state, speed and switch history; advance once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      speed_q   <= '0;
      prev_sw_q <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      speed_q   <= speed_d;
      prev_sw_q <= item_i.switches;
    end
  end

  assign speed_o = speed_q;
  assign state_o = state_q;

endmodule

@@ rtl/door_motion_profile_fsm_unit.sv @@
// Top level of the door motion profile block: stream ports, input stage,
// configuration port. Depends on dmp_pkg, dmp_cfg_regs and dmp_fsm.
`timescale 1ns / 1ps

// Each transfer on the slave stream is one control tick (commanded direction
// and the four position switches) and yields exactly one result on the master
// stream: the signed motor speed and the new door state code. A tick passes
// through an input register and then the state machine, whose state and speed
// registers are the result register, so a result is valid on the master side
// once the state machine has stepped on its tick, and one tick is accepted
// every cycle while the master side keeps up. Speed magnitudes are written
// through the configuration port (index 0 creep, 1 slow, 2 fast, index 3
// ignored) while no tick is in flight; it is always ready.

module door_motion_profile_fsm_unit import dmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // bits: 0 direction, 1 open_end_switch, 2 open_zone_switch,
  //       3 close_zone_switch, 4 close_end_switch, 7:5 zero
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // bits: 12:0 motor_speed (signed), 16:13 door_state, 23:17 zero
  output logic [23:0]          m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [SpeedMagW-1:0] cfg_data_i
);

  logic                     in_valid_q;
  dmp_item_t                item_q;
  logic                     out_valid_q;
  logic                     advance;
  logic                     in_fire;
  dmp_cfg_t                 cfg;
  logic signed [SpeedW-1:0] speed;
  logic [StateW-1:0]        state_code;

  // Move the pipeline when the result register is free or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Input stage valid and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire)      in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)      out_valid_q <= in_valid_q;
    end
  end

  // Capture the tick on transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.direction <= s_axis_tdata[0];
      item_q.switches  <= s_axis_tdata[SwitchN:1];
    end
  end

  dmp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dmp_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance && in_valid_q),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .speed_o (speed),
    .state_o (state_code)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, state_code, speed};

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for door_motion_profile_fsm_unit: directed homing and
// zone sequences, then random door walks under several speed settings.
// Depends on dmp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import dmp_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned WalkPhases    = 4;
  localparam int unsigned WalkTicks     = 112;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned IdlePercent   = 10;

  // Door state codes as carried in the result
  typedef enum logic [StateW-1:0] {
    DoorInit       = 4'd0,
    DoorUnknown    = 4'd1,
    DoorClosed     = 4'd2,
    DoorOpenAccel  = 4'd3,
    DoorOpenFast   = 4'd4,
    DoorOpenDecel  = 4'd5,
    DoorOpened     = 4'd6,
    DoorCloseAccel = 4'd7,
    DoorCloseFast  = 4'd8,
    DoorCloseDecel = 4'd9
  } door_state_e;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    door_state_e              state;
  } door_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [SpeedMagW-1:0] cfg_data_i;

  // Predicted door state, speed and switch history
  door_state_e              door_state;
  logic signed [SpeedW-1:0] held_speed;
  logic [SwitchN-1:0]       last_switches;
  dmp_cfg_t                 speeds;

  dmp_item_t    pending_ticks[$];
  door_result_t expected_results[$];
  dmp_item_t    tick_on_bus;

  int unsigned queued_ticks;
  int unsigned accepted_ticks;
  int unsigned checked_results;
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_left;
  logic        hold_start;
  logic        steady;

  door_motion_profile_fsm_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Advance the door profile by one tick and return the speed and state it yields
  function automatic door_result_t advance_door(input dmp_item_t tick);
    logic [SwitchN-1:0]       ev;
    logic                     dir;
    logic signed [SpeedW-1:0] creep;
    logic signed [SpeedW-1:0] slow;
    logic signed [SpeedW-1:0] fast;
    door_result_t             res;
    ev    = tick.switches ^ last_switches;
    dir   = tick.direction;
    creep = $signed({1'b0, speeds.creep});
    slow  = $signed({1'b0, speeds.slow});
    fast  = $signed({1'b0, speeds.fast});
    case (door_state)
      DoorUnknown: begin
        if (dir) begin
          held_speed = creep;
          if (ev[SwCloseEnd]) door_state = DoorClosed;
        end else begin
          held_speed = -creep;
          if (ev[SwOpenEnd]) door_state = DoorOpened;
        end
      end
      DoorClosed: begin
        held_speed = '0;
        if (!dir) door_state = DoorOpenAccel;
      end
      DoorOpenAccel: begin
        held_speed = -slow;
        if (ev[SwCloseZone]) door_state = DoorOpenFast;
        else if (dir) door_state = DoorCloseDecel;
      end
      DoorOpenFast: begin
        held_speed = -fast;
        if (ev[SwOpenZone]) door_state = DoorOpenDecel;
        else if (dir) door_state = DoorCloseFast;
      end
      DoorOpenDecel: begin
        held_speed = -slow;
        if (ev[SwOpenEnd]) door_state = DoorOpened;
        else if (dir) door_state = DoorCloseAccel;
      end
      DoorOpened: begin
        held_speed = '0;
        if (dir) door_state = DoorCloseAccel;
      end
      DoorCloseAccel: begin
        held_speed = slow;
        if (ev[SwOpenZone]) door_state = DoorCloseFast;
        else if (!dir) door_state = DoorOpenDecel;
      end
      DoorCloseFast: begin
        held_speed = fast;
        if (ev[SwCloseZone]) door_state = DoorCloseDecel;
        else if (!dir) door_state = DoorOpenFast;
      end
      DoorCloseDecel: begin
        held_speed = slow;
        if (ev[SwCloseEnd]) door_state = DoorClosed;
        else if (!dir) door_state = DoorOpenAccel;
      end
      // init, and any unused code, moves on to homing with the speed held
      default: door_state = DoorUnknown;
    endcase
    last_switches = tick.switches;
    res.speed = held_speed;
    res.state = door_state;
    return res;
  endfunction

  task automatic queue_tick(input logic dir, input logic [SwitchN-1:0] sw);
    dmp_item_t t;
    t.direction = dir;
    t.switches  = sw;
    pending_ticks.push_back(t);
    queued_ticks++;
  endtask

  // Write one speed register; index 3 is accepted but changes nothing
  task automatic write_speed(input logic [CfgIdxW-1:0] idx, input logic [SpeedMagW-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCreep: speeds.creep = value;
      RegSlow:  speeds.slow  = value;
      RegFast:  speeds.fast  = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every queued tick is taken and every result has come back
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (accepted_ticks != queued_ticks || expected_results.size() != 0);
  endtask

  // Tick driver: offer the next pending tick, idling now and then
  always @(posedge clk_i) begin : drive_ticks
    dmp_item_t next_tick;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(advance_door(tick_on_bus));
        accepted_ticks++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IdlePercent)) begin
          next_tick = pending_ticks.pop_front();
          tick_on_bus   <= next_tick;
          s_axis_tdata  <= {3'b000, next_tick.switches, next_tick.direction};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    door_result_t             want;
    logic signed [SpeedW-1:0] got_speed;
    logic [StateW-1:0]        got_state;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_speed = m_axis_tdata[SpeedW-1:0];
        got_state = m_axis_tdata[SpeedW +: StateW];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual speed %0d state %0d",
                   $time, got_speed, got_state);
        end else begin
          want = expected_results.pop_front();
          checked_results++;
          if (got_speed !== want.speed) begin
            errors++;
            $display("%0t: motor_speed mismatch, expected %0d, actual %0d",
                     $time, want.speed, got_speed);
          end
          if (got_state !== want.state) begin
            errors++;
            $display("%0t: door_state mismatch, expected %0d, actual %0d",
                     $time, want.state, got_state);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IdlePercent);
    end
  end

  // Count down a long receiver hold-off once it is requested
  always @(posedge clk_i) begin : count_hold_off
    if (hold_start) begin
      hold_left <= HoldOffCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drop the run if it never drains
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still expected",
               $time, cycles, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_test
    int unsigned        phase_idx;
    int unsigned        n;
    logic [SwitchN-1:0] walk_sw;
    logic               walk_dir;

    rst_ni          = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tvalid   = 1'b0;
    m_axis_tready   = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    tick_on_bus     = '0;
    hold_start      = 1'b0;
    hold_left       = 0;
    steady          = 1'b0;
    queued_ticks    = 0;
    accepted_ticks  = 0;
    checked_results = 0;
    errors          = 0;
    cycles          = 0;
    door_state      = DoorInit;
    held_speed      = '0;
    last_switches   = '0;
    speeds.creep    = CreepRst;
    speeds.slow     = SlowRst;
    speeds.fast     = FastRst;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leave init, home toward closed (wrong-end events ignored),
    // walk every zone, reversals, and zone events racing a reversal.
    // Switch vector reads close_end, close_zone, open_zone, open_end.
    queue_tick(1'b0, 4'b0000);
    queue_tick(1'b0, 4'b0000);
    queue_tick(1'b1, 4'b0000);
    queue_tick(1'b1, 4'b0001);
    queue_tick(1'b0, 4'b1001);
    queue_tick(1'b1, 4'b1001);
    queue_tick(1'b1, 4'b0001);
    queue_tick(1'b1, 4'b0001);
    queue_tick(1'b0, 4'b0001);
    queue_tick(1'b0, 4'b0001);
    queue_tick(1'b0, 4'b0101);
    queue_tick(1'b0, 4'b0101);
    queue_tick(1'b1, 4'b0101);
    queue_tick(1'b1, 4'b0101);
    queue_tick(1'b0, 4'b0101);
    queue_tick(1'b0, 4'b0111);
    queue_tick(1'b1, 4'b0110);
    queue_tick(1'b0, 4'b0110);
    queue_tick(1'b1, 4'b0110);
    queue_tick(1'b0, 4'b0100);
    queue_tick(1'b1, 4'b0000);
    queue_tick(1'b0, 4'b0000);
    queue_tick(1'b1, 4'b0000);
    queue_tick(1'b1, 4'b1000);
    queue_tick(1'b0, 4'b0111);
    queue_tick(1'b1, 4'b1000);
    queue_tick(1'b1, 4'b1000);
    wait_until_drained();

    walk_sw  = 4'b1000;
    walk_dir = 1'b1;
    for (phase_idx = 0; phase_idx < WalkPhases; phase_idx++) begin
      // Block is idle here: every result of the previous phase is in
      case (phase_idx)
        0: begin
          write_speed(RegCreep, '0);
          write_speed(RegSlow, '1);
          write_speed(RegFast, '0);
          write_speed(2'd3, SpeedMagW'($urandom_range(4095)));
        end
        1: begin
          write_speed(RegCreep, '1);
          write_speed(RegSlow, '0);
          write_speed(RegFast, '1);
        end
        2: begin
          write_speed(RegCreep, SpeedMagW'($urandom_range(4095)));
          write_speed(RegSlow, SpeedMagW'($urandom_range(4095)));
          write_speed(RegFast, SpeedMagW'($urandom_range(4095)));
        end
        default: begin
          write_speed(RegCreep, CreepRst);
          write_speed(RegSlow, SlowRst);
          write_speed(RegFast, FastRst);
        end
      endcase
      steady <= (phase_idx == 1);

      // Door walks: mostly single switch changes and rare reversals, some noise
      for (n = 0; n < WalkTicks; n++) begin
        if ($urandom_range(99) < 15) begin
          walk_dir = 1'($urandom_range(1));
          walk_sw  = SwitchN'($urandom_range(15));
        end else begin
          if ($urandom_range(99) < 8) walk_dir = ~walk_dir;
          if ($urandom_range(99) < 35) walk_sw[2'($urandom_range(SwitchN - 1))] ^= 1'b1;
        end
        queue_tick(walk_dir, walk_sw);
      end

      // Stall the receiver while ticks keep coming so the input backs up
      if (phase_idx == 2) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      wait_until_drained();
    end
    steady <= 1'b0;

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("Ran %0d ticks with %0d results checked: homing, all zones, reversals,",
             accepted_ticks, checked_results);
    $display("speed extremes, an ignored register index and a long output stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
